/* design/tcw_pkg.sv */
// Shared types and constants for the text console character writer.
// Word layouts of the stream ports, operation and control codes, defaults.
// No dependencies.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int IN_W   = 40;
    localparam int OUT_W  = 40;
    localparam int FUNC_W = 2;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;
    localparam logic [7:0]        BLANK_CHAR = 8'h20;
    localparam logic [CELL_W-1:0] INIT_CELL  = 16'h0020;

    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_BS  = 8'd8;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    typedef struct packed {
        logic              pad;
        logic [10:0]       cell_index;
        logic signed [9:0] cursor_y;
        logic signed [9:0] cursor_x;
        logic [7:0]        char_code;
    } in_word_t;

    typedef struct packed {
        logic              scrolled;
        logic [CELL_W-1:0] cell_data;
        logic [6:0]        cursor_col;
        logic [4:0]        cursor_row;
        logic [10:0]       cursor_position;
    } out_word_t;

endpackage

/* design/tcw_cell_mem.sv */
// Screen cell store: simple dual-port synchronous RAM, one write and one read port.
// Read data registered. No dependencies.
module tcw_cell_mem #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] cells_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cells_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cells_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/tcw_ctrl.sv */
// Console sequencer: cursor state, operation decode, scroll/clear/init sweeps
// over the cell store, and the result output register. Uses tcw_pkg.
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tcw_pkg::IN_W-1:0]    s_tdata,
    input  logic [tcw_pkg::FUNC_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tcw_pkg::OUT_W-1:0]   m_tdata,
    input  logic [tcw_pkg::ATTR_W-1:0]  attr,
    output logic                        mem_wr_en,
    output logic [ADDR_W-1:0]           mem_wr_addr,
    output logic [tcw_pkg::CELL_W-1:0]  mem_wr_data,
    output logic                        mem_rd_en,
    output logic [ADDR_W-1:0]           mem_rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  mem_rd_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int CXW   = $clog2(COLUMNS + 4);
    localparam int RW    = $clog2(ROWS);
    localparam int RXW   = $clog2(ROWS + 1);
    localparam int SW    = $clog2(CELLS + 1);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [SW-1:0]     src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic              pend_reg, pend_next;
    logic              scr_reg, scr_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    in_word_t            in_w;
    out_word_t           out_w;
    logic                accept;
    logic [CELL_W-1:0]   blank;
    logic [CXW-1:0]      put_col;
    logic [RXW-1:0]      put_row;
    logic                put_we;
    logic [CW-1:0]       put_wcol;
    logic [CELL_W-1:0]   put_data;
    logic                put_scroll;
    logic [ADDR_W-1:0]   row_base;
    logic [ADDR_W-1:0]   pos;
    logic [ADDR_W+10:0]  pos_w;
    logic [RW+4:0]       row_w;
    logic [CW+6:0]       col_w;
    logic [ADDR_W+10:0]  idx_w;
    logic                idx_ok;
    logic                src_live;
    logic [CW-1:0]       set_col;
    logic [RW-1:0]       set_row;

    assign in_w     = in_word_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign blank    = {attr, BLANK_CHAR};
    assign row_base = ADDR_W'(row_reg) * ADDR_W'(COLUMNS);
    assign pos      = row_base + ADDR_W'(col_reg);
    assign pos_w    = {11'd0, pos};
    assign row_w    = {5'd0, row_reg};
    assign col_w    = {7'd0, col_reg};
    assign idx_w    = {ADDR_W'(0), in_w.cell_index};
    assign idx_ok   = idx_w < (ADDR_W + 11)'(CELLS);
    assign src_live = src_reg < SW'(CELLS);

    always_comb
    begin
        put_col  = CXW'(col_reg);
        put_row  = RXW'(row_reg);
        put_we   = 1'b0;
        put_wcol = col_reg;
        put_data = {attr, in_w.char_code};
        case (in_w.char_code)
            CH_NL:
            begin
                put_col = '0;
                put_row = RXW'(row_reg) + RXW'(1);
            end
            CH_CR:
            begin
                put_col = '0;
            end
            CH_TAB:
            begin
                put_col = (CXW'(col_reg) + CXW'(4)) & ~CXW'(3);
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    put_col  = CXW'(col_reg) - CXW'(1);
                    put_wcol = col_reg - CW'(1);
                end
                put_we   = 1'b1;
                put_data = blank;
            end
            default:
            begin
                put_we  = 1'b1;
                put_col = CXW'(col_reg) + CXW'(1);
            end
        endcase
        if (put_col >= CXW'(COLUMNS))
        begin
            put_col = '0;
            put_row = put_row + RXW'(1);
        end
        put_scroll = (put_row >= RXW'(ROWS));
        if (put_scroll)
        begin
            put_row = RXW'(ROWS - 1);
        end
    end

    always_comb
    begin
        if (in_w.cursor_x[9])
        begin
            set_col = '0;
        end
        else if ({1'b0, in_w.cursor_x[8:0]} >= 10'(COLUMNS))
        begin
            set_col = CW'(COLUMNS - 1);
        end
        else
        begin
            set_col = CW'(in_w.cursor_x[8:0]);
        end
        if (in_w.cursor_y[9])
        begin
            set_row = '0;
        end
        else if (in_w.cursor_y[8:0] >= 9'(ROWS))
        begin
            set_row = RW'(ROWS - 1);
        end
        else
        begin
            set_row = RW'(in_w.cursor_y[8:0]);
        end
    end

    always_comb
    begin
        out_w.scrolled        = scr_reg;
        out_w.cell_data       = cell_reg;
        out_w.cursor_col      = col_w[6:0];
        out_w.cursor_row      = row_w[4:0];
        out_w.cursor_position = pos_w[10:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        pend_next     = pend_reg;
        scr_next      = scr_reg;
        cell_next     = cell_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = dst_reg;
        mem_wr_data   = blank;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = src_reg[ADDR_W-1:0];

        case (state_reg)
            ST_INIT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = INIT_CELL;
                dst_next    = dst_reg + ADDR_W'(1);
                if (dst_reg == ADDR_W'(CELLS - 1))
                begin
                    dst_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    scr_next   = 1'b0;
                    cell_next  = '0;
                    state_next = ST_DONE;
                    case (s_tuser)
                        FUNC_PUT:
                        begin
                            mem_wr_en   = put_we;
                            mem_wr_addr = row_base + ADDR_W'(put_wcol);
                            mem_wr_data = put_data;
                            col_next    = CW'(put_col);
                            row_next    = RW'(put_row);
                            if (put_scroll)
                            begin
                                scr_next   = 1'b1;
                                src_next   = SW'(COLUMNS);
                                dst_next   = '0;
                                pend_next  = 1'b0;
                                state_next = ST_SCROLL;
                            end
                        end
                        FUNC_SET:
                        begin
                            col_next = set_col;
                            row_next = set_row;
                        end
                        FUNC_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            dst_next   = '0;
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                            if (idx_ok)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = idx_w[ADDR_W-1:0];
                                state_next  = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cell_next  = mem_rd_data;
                state_next = ST_DONE;
            end
            ST_SCROLL:
            begin
                mem_rd_en = src_live;
                pend_next = src_live;
                if (src_live)
                begin
                    src_next = src_reg + SW'(1);
                end
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = mem_rd_data;
                    dst_next    = dst_reg + ADDR_W'(1);
                end
                if (!src_live && !pend_reg)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                mem_wr_en = 1'b1;
                dst_next  = dst_reg + ADDR_W'(1);
                if (dst_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = out_w;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scr_reg     <= scr_next;
        cell_reg    <= cell_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/text_console_character_writer_unit.sv */
// Sequence, input handshake to result handshake: put/set go straight to the done state;
// read passes a read state first (skipped when out of range); clear writes blank to every
// cell; scroll copies each cell up one row, then blanks the bottom row. One word at a time;
// next word accepted once the previous result is in the output register, where it may wait.
// Reset: cursor home, attribute 7; a pass writes 0x0020 to every cell, with s_tready low
// until it ends. Depends on tcw_pkg, tcw_ctrl and tcw_cell_mem.
module text_console_character_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // char_code[7:0], cursor_x[17:8], cursor_y[27:18], cell_index[38:28], zero[39]
    input  logic [tcw_pkg::IN_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [tcw_pkg::FUNC_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // cursor_position[10:0], cursor_row[15:11], cursor_col[22:16],
    // cell_data[38:23], scrolled[39]
    output logic [tcw_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [CELL_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [CELL_W-1:0] mem_rd_data;

    assign cfg_ready = 1'b1;
    assign attr_next = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .attr        (attr_reg),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tcw_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

/* design/tcw_checker.sv */
// Port-level checks for the text console character writer, bound to the top.
// Depends on tcw_pkg and text_console_character_writer_unit.
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [tcw_pkg::OUT_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39] |->
            m_tdata[22:16] == 7'd0 && m_tdata[15:11] == 5'(ROWS - 1))
        else $error("scroll left cursor off the bottom row start");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[22:16]) < COLUMNS)
        else $error("cursor column out of screen");

    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("input ready during cell clearing pass");

endmodule

bind text_console_character_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
